/* rtl/tmf_pkg.sv */
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared types and constants for the triangular membership fuzzifier.
// ----------------------------------------------------------------------------
package tmf_pkg;

  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned CORNER_W  = 8;
  localparam int unsigned DEG_W     = 16;
  localparam int unsigned REM_W     = CORNER_W + 1;
  localparam int unsigned N_CELLS   = FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = CFG_IDX_W'(2);

  localparam logic [CORNER_W-1:0] LEFT_RST  = CORNER_W'(0);
  localparam logic [CORNER_W-1:0] PEAK_RST  = CORNER_W'(128);
  localparam logic [CORNER_W-1:0] RIGHT_RST = CORNER_W'(255);

  localparam logic [DEG_W-1:0] UNIT_DEGREE = DEG_W'(64'd1 << FRAC_BITS);

  // item travelling down the divider chain
  typedef struct packed {
    logic                ovr;      // result fixed, no quotient
    logic                ovr_one;  // fixed result is 1.0 (else 0)
    logic [CORNER_W-1:0] den;
    logic [REM_W-1:0]    rem;
    logic [DEG_W-1:0]    quot;
  } cell_t;

endpackage

/* rtl/tmf_classify.sv */
// ----------------------------------------------------------------------------
// tmf_classify
// Head cell: picks shoulder / triangle rule, forms numerator and denominator.
// ----------------------------------------------------------------------------
module tmf_classify (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [tmf_pkg::CORNER_W-1:0]  sample_i,
  input  logic [tmf_pkg::CORNER_W-1:0]  left_i,
  input  logic [tmf_pkg::CORNER_W-1:0]  peak_i,
  input  logic [tmf_pkg::CORNER_W-1:0]  right_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output tmf_pkg::cell_t                data_o
);
  import tmf_pkg::*;

  logic                valid_q;
  cell_t               data_q, data_d;
  logic                ovr, ovr_one, use_rise;
  logic [CORNER_W-1:0] rise_num, rise_den, fall_num, fall_den;

  assign rise_num = sample_i - left_i;
  assign rise_den = peak_i - left_i;
  assign fall_num = right_i - sample_i;
  assign fall_den = right_i - peak_i;

  always_comb begin
    ovr      = 1'b0;
    ovr_one  = 1'b0;
    use_rise = 1'b0;
    if (peak_i == left_i) begin
      if (sample_i < left_i) begin
        ovr     = 1'b1;
        ovr_one = 1'b1;
      end else if (sample_i > right_i) begin
        ovr = 1'b1;
      end else if (right_i == peak_i) begin
        ovr     = 1'b1;
        ovr_one = 1'b1;
      end
    end else if (peak_i == right_i) begin
      use_rise = 1'b1;
      if (sample_i > right_i) begin
        ovr     = 1'b1;
        ovr_one = 1'b1;
      end else if (sample_i < left_i) begin
        ovr = 1'b1;
      end
    end else if ((sample_i > left_i) && (sample_i < peak_i)) begin
      use_rise = 1'b1;
    end else if ((sample_i > peak_i) && (sample_i < right_i)) begin
      use_rise = 1'b0;
    end else if (sample_i == peak_i) begin
      ovr     = 1'b1;
      ovr_one = 1'b1;
    end else begin
      ovr = 1'b1;
    end

    data_d.ovr     = ovr;
    data_d.ovr_one = ovr_one;
    data_d.den     = use_rise ? rise_den : fall_den;
    data_d.rem     = {1'b0, (use_rise ? rise_num : fall_num)};
    data_d.quot    = '0;
    if (ovr) begin
      data_d.den = CORNER_W'(1);
      data_d.rem = '0;
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/tmf_div_cell.sv */
// ----------------------------------------------------------------------------
// tmf_div_cell
// One restoring-division cell: resolves one quotient bit per item.
// ----------------------------------------------------------------------------
module tmf_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tmf_pkg::cell_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output tmf_pkg::cell_t data_o
);
  import tmf_pkg::*;

  logic                valid_q;
  cell_t               data_q, data_d;
  logic                ge;
  logic [REM_W-1:0]    diff;

  assign ge   = data_i.rem >= {1'b0, data_i.den};
  assign diff = ge ? (data_i.rem - {1'b0, data_i.den}) : data_i.rem;

  always_comb begin
    data_d      = data_i;
    // diff < den, so it fits the corner width before the shift
    data_d.rem  = {diff[CORNER_W-1:0], 1'b0};
    data_d.quot = {data_i.quot[DEG_W-2:0], ge};
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/triangular_membership_fuzzifier_core.sv */
// ----------------------------------------------------------------------------
// triangular_membership_fuzzifier_core
// Triangular / shoulder fuzzy membership, Q1.15 degree, pipelined divider.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir
//  input   | in_valid_i, in_ready_o, sample_i      | in
//  result  | out_valid_o, out_ready_i, degree_o    | out
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i,| in
//          | cfg_data_i                            |
//
// One item per cycle sustained while results are taken; the stages are one
// classify cell, one divider cell per quotient bit, one output register.
// Every cell holds its item under stall and takes a new one as soon as it
// empties, so bubbles collapse. Reset empties the chain and loads the
// corner defaults. Config writes are always taken.
module triangular_membership_fuzzifier_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tmf_pkg::CORNER_W-1:0]   sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tmf_pkg::DEG_W-1:0]      degree_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmf_pkg::CORNER_W-1:0]   cfg_data_i
);
  import tmf_pkg::*;

  logic [CORNER_W-1:0] left_q, peak_q, right_q;
  logic                chain_valid [N_CELLS+1];
  logic                chain_ready [N_CELLS+1];
  cell_t               chain_data  [N_CELLS+1];
  logic                out_valid_q;
  logic [DEG_W-1:0]    degree_q, degree_d;
  logic                out_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LEFT_RST;
      peak_q  <= PEAK_RST;
      right_q <= RIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEFT:  left_q  <= cfg_data_i;
        CFG_PEAK:  peak_q  <= cfg_data_i;
        CFG_RIGHT: right_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tmf_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .sample_i (sample_i),
    .left_i   (left_q),
    .peak_i   (peak_q),
    .right_i  (right_q),
    .valid_o  (chain_valid[0]),
    .ready_i  (chain_ready[0]),
    .data_o   (chain_data[0])
  );

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    tmf_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // output register
  assign chain_ready[N_CELLS] = ~out_valid_q | out_ready_i;
  assign out_load = chain_valid[N_CELLS] & chain_ready[N_CELLS];

  always_comb begin
    degree_d = chain_data[N_CELLS].quot;
    if (chain_data[N_CELLS].ovr) begin
      degree_d = chain_data[N_CELLS].ovr_one ? UNIT_DEGREE : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[N_CELLS]) begin
      out_valid_q <= chain_valid[N_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      degree_q <= degree_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign degree_o    = degree_q;

endmodule

/* rtl/tmf_checker.sv */
// ----------------------------------------------------------------------------
// tmf_checker
// Port-level checks on the fuzzifier core, bound to the top level.
// ----------------------------------------------------------------------------
module tmf_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_o,
  input  logic [tmf_pkg::CORNER_W-1:0]   sample_i,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [tmf_pkg::DEG_W-1:0]      degree_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  logic [tmf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tmf_pkg::CORNER_W-1:0]   cfg_data_i
);
  import tmf_pkg::*;

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(degree_o))
    else $error("result changed while stalled");

  // degree never exceeds 1.0
  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> degree_o <= UNIT_DEGREE)
    else $error("degree above unit");

  // input only backs up when the whole chain is full behind a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // config never stalls
  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind triangular_membership_fuzzifier_core tmf_checker u_tmf_checker (.*);
